// File: hdl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, constants and the rotate function shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPRESS,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_byte;
		logic load_pad;
		logic load_len;
		logic start_round;
		logic step_round;
		logic finish_block;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic       last_round;
		logic       pad_second;
	} status_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// File: hdl/sha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for message beats and digest beats.
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              has_byte,
	input  logic              end_of_message,
	input  logic              block_full,
	input  sha_pkg::status_t  status,
	output sha_pkg::cmd_t     cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        word_index,
	output logic              last_word
);

	sha_pkg::state_t state_q, state_d;
	logic            fin_q, fin_d;
	logic            pad_done_q, pad_done_d;
	logic            len_done_q, len_done_d;
	logic [2:0]      idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha_pkg::ST_IDLE;
			fin_q      <= 1'b0;
			pad_done_q <= 1'b0;
			len_done_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q    <= state_d;
			fin_q      <= fin_d;
			pad_done_q <= pad_done_d;
			len_done_q <= len_done_d;
			idx_q      <= idx_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fin_d      = fin_q;
		pad_done_d = pad_done_q;
		len_done_d = len_done_q;
		idx_d      = idx_q;
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_byte = has_byte;
					fin_d         = end_of_message;
					pad_done_d    = 1'b0;
					len_done_d    = 1'b0;
					if (has_byte && block_full) begin
						cmd.start_round = 1'b1;
						state_d         = sha_pkg::ST_COMPRESS;
					end else if (end_of_message) begin
						state_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_COMPRESS: begin
				cmd.step_round = 1'b1;
				if (status.last_round) begin
					cmd.finish_block = 1'b1;
					if (!fin_q) begin
						state_d = sha_pkg::ST_IDLE;
					end else if (!pad_done_q) begin
						state_d = sha_pkg::ST_PAD;
					end else if (!len_done_q) begin
						state_d = sha_pkg::ST_LEN;
					end else begin
						idx_d   = '0;
						state_d = sha_pkg::ST_EMIT;
					end
				end
			end
			sha_pkg::ST_PAD: begin
				cmd.load_pad = 1'b1;
				pad_done_d   = 1'b1;
				if (status.pad_second) begin
					cmd.start_round = 1'b1;
					state_d         = sha_pkg::ST_COMPRESS;
				end else begin
					state_d = sha_pkg::ST_LEN;
				end
			end
			sha_pkg::ST_LEN: begin
				cmd.load_len    = 1'b1;
				cmd.start_round = 1'b1;
				len_done_d      = 1'b1;
				state_d         = sha_pkg::ST_COMPRESS;
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.restart = 1'b1;
						fin_d       = 1'b0;
						state_d     = sha_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd7);

endmodule

// File: hdl/sha_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte counter, message schedule, round registers and hash.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::cmd_t     cmd,
	input  logic [7:0]        data_byte,
	input  logic [2:0]        word_index,
	output logic              block_full,
	output sha_pkg::status_t  status,
	output logic [31:0]       digest_word
);

	logic [31:0] buf_q [16];
	logic [31:0] hash_q [8];
	logic [31:0] wrk_q [8];
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [5:0]  pos;
	logic [7:0]  put_byte;
	logic        put_en;
	logic [31:0] w_t, s0, s1, w_new, t1, t2, ep1, ep0, ch, maj;
	logic [63:0] bits;

	assign pos        = len_q[5:0];
	assign block_full = (pos == 6'd63);
	assign put_en     = cmd.load_byte | cmd.load_pad;
	assign put_byte   = cmd.load_pad ? sha_pkg::PAD_BYTE : data_byte;
	assign bits       = {len_q[60:0], 3'b000};

	always_comb begin
		status.last_round = (rnd_q == 6'd63);
		status.pad_second = (pos >= 6'd56);
	end

	assign s0 = sha_pkg::rotr(buf_q[1], 7) ^ sha_pkg::rotr(buf_q[1], 18) ^ (buf_q[1] >> 3);
	assign s1 = sha_pkg::rotr(buf_q[14], 17) ^ sha_pkg::rotr(buf_q[14], 19)
		^ (buf_q[14] >> 10);
	assign w_new = buf_q[0] + s0 + buf_q[9] + s1;
	assign w_t   = buf_q[0];
	assign ep1 = sha_pkg::rotr(wrk_q[4], 6) ^ sha_pkg::rotr(wrk_q[4], 11)
		^ sha_pkg::rotr(wrk_q[4], 25);
	assign ep0 = sha_pkg::rotr(wrk_q[0], 2) ^ sha_pkg::rotr(wrk_q[0], 13)
		^ sha_pkg::rotr(wrk_q[0], 22);
	assign ch  = (wrk_q[4] & wrk_q[5]) ^ (~wrk_q[4] & wrk_q[6]);
	assign maj = (wrk_q[0] & wrk_q[1]) ^ (wrk_q[0] & wrk_q[2]) ^ (wrk_q[1] & wrk_q[2]);
	assign t1  = wrk_q[7] + ep1 + ch + sha_pkg::ROUND_K[rnd_q] + w_t;
	assign t2  = ep0 + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
		end else begin
			if (cmd.restart) begin
				len_q <= '0;
				for (int i = 0; i < 16; i++) buf_q[i] <= '0;
				for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::INIT_HASH[i];
			end else if (cmd.step_round) begin
				for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
				buf_q[15] <= w_new;
				rnd_q     <= rnd_q + 6'd1;
				if (cmd.finish_block) begin
					for (int i = 0; i < 16; i++) buf_q[i] <= '0;
					hash_q[0] <= hash_q[0] + t1 + t2;
					hash_q[1] <= hash_q[1] + wrk_q[0];
					hash_q[2] <= hash_q[2] + wrk_q[1];
					hash_q[3] <= hash_q[3] + wrk_q[2];
					hash_q[4] <= hash_q[4] + wrk_q[3] + t1;
					hash_q[5] <= hash_q[5] + wrk_q[4];
					hash_q[6] <= hash_q[6] + wrk_q[5];
					hash_q[7] <= hash_q[7] + wrk_q[6];
				end
			end else begin
				if (put_en) begin
					case (pos[1:0])
						2'd0: buf_q[pos[5:2]][31:24] <= put_byte;
						2'd1: buf_q[pos[5:2]][23:16] <= put_byte;
						2'd2: buf_q[pos[5:2]][15:8]  <= put_byte;
						default: buf_q[pos[5:2]][7:0] <= put_byte;
					endcase
				end
				if (cmd.load_byte) len_q <= len_q + 64'd1;
				if (cmd.load_len) begin
					buf_q[14] <= bits[63:32];
					buf_q[15] <= bits[31:0];
				end
				if (cmd.start_round) rnd_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_round) begin
			for (int i = 0; i < 8; i++) wrk_q[i] <= hash_q[i];
		end else if (cmd.step_round) begin
			wrk_q[0] <= t1 + t2;
			wrk_q[1] <= wrk_q[0];
			wrk_q[2] <= wrk_q[1];
			wrk_q[3] <= wrk_q[2];
			wrk_q[4] <= wrk_q[3] + t1;
			wrk_q[5] <= wrk_q[4];
			wrk_q[6] <= wrk_q[5];
			wrk_q[7] <= wrk_q[6];
		end
	end

	assign digest_word = hash_q[word_index];

endmodule

// File: hdl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// A beat that does not complete a 64-byte block is taken while the controller
// is idle. A beat that completes a block holds off the input while the single
// round unit runs one round per cycle. An end-of-message beat adds a padding
// step, a length step and one or two compressions, then the eight digest beats
// go out one per cycle as the sink takes them.
module sha256_stream_hasher (
	input logic         clk,
	input logic         arst_n,
	sha_in_if.sink      in_ch,
	sha_out_if.source   out_ch
);

	sha_pkg::cmd_t    cmd;
	sha_pkg::status_t status;
	logic             block_full;
	logic [2:0]       word_index;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.has_byte       (in_ch.has_byte),
		.end_of_message (in_ch.end_of_message),
		.block_full     (block_full),
		.status         (status),
		.cmd            (cmd),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.word_index     (word_index),
		.last_word      (out_ch.last_word)
	);

	sha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (in_ch.data_byte),
		.word_index  (word_index),
		.block_full  (block_full),
		.status      (status),
		.digest_word (out_ch.digest_word)
	);

	assign out_ch.word_index = word_index;

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ch.ready && out_ch.valid))
		else $error("Input and output active together.");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready)
		else $error("No return to idle after last digest beat.");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_byte, cmd.load_pad, cmd.load_len, cmd.step_round}))
		else $error("Conflicting datapath commands.");

endmodule
